// ----- rtl/dcrm_pkg.sv -----
// ----------------------------------------------------------------------------
// dcrm_pkg: shared types and constants of the dual channel running median
// Word layouts, window geometry and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcrm_pkg;

	// window geometry
	localparam int WINDOW   = 5;
	localparam int TAG_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W    = $clog2(WINDOW + 1);

	// sample arithmetic
	localparam int CODE_W   = 12;
	localparam int GAIN_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int SAMPLE_W = 20;
	localparam int PROD_W   = CODE_W + GAIN_W;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = GAIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = 32'h0001_0000;

	// input word
	typedef struct packed {
		logic [CODE_W-1:0] raw_voltage;
		logic [CODE_W-1:0] raw_current;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [SAMPLE_W-1:0] voltage_median;
		logic [SAMPLE_W-1:0] current_median;
		logic                valid_res;
	} out_word_t;

	// one window cell: occupied flag, ring slot it came from, sample
	typedef struct packed {
		logic                vld;
		logic [TAG_W-1:0]    tag;
		logic [SAMPLE_W-1:0] val;
	} entry_t;

endpackage

`default_nettype wire

// ----- rtl/dcrm_scale.sv -----
// ----------------------------------------------------------------------------
// dcrm_scale: gain scaling of one ADC code
// Q16.16 multiply, fraction truncated, result saturated to the sample width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcrm_scale (
	input  wire logic [dcrm_pkg::CODE_W-1:0]   code,
	input  wire logic [dcrm_pkg::GAIN_W-1:0]   gain,
	output logic      [dcrm_pkg::SAMPLE_W-1:0] sample
);

	logic [dcrm_pkg::PROD_W-1:0]                  prod;
	logic [dcrm_pkg::PROD_W-dcrm_pkg::FRAC_W-1:0] whole;

	// full product, then drop the fraction
	assign prod  = dcrm_pkg::PROD_W'(code) * dcrm_pkg::PROD_W'(gain);
	assign whole = prod[dcrm_pkg::PROD_W-1:dcrm_pkg::FRAC_W];

	// clamp anything above the sample range
	always_comb begin
		if (|whole[dcrm_pkg::PROD_W-dcrm_pkg::FRAC_W-1:dcrm_pkg::SAMPLE_W]) begin
			sample = '1;
		end else begin
			sample = whole[dcrm_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dcrm_cell.sv -----
// ----------------------------------------------------------------------------
// dcrm_cell: one cell of the sorted window chain
// Holds one sample; on update takes its new content from its neighbours,
// itself or the incoming sample so the chain stays sorted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcrm_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          upd,
	input  wire logic [dcrm_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [dcrm_pkg::TAG_W-1:0]    slot,
	input  wire dcrm_pkg::entry_t              left,
	input  wire logic                          left_lf,
	input  wire logic                          ev_prev,
	input  wire dcrm_pkg::entry_t              right,
	input  wire logic                          right_lf,
	output dcrm_pkg::entry_t                   entry,
	output logic                               lf,
	output logic                               ev_le
);

	logic                          vld_q;
	logic [dcrm_pkg::TAG_W-1:0]    tag_q;
	logic [dcrm_pkg::SAMPLE_W-1:0] val_q;

	dcrm_pkg::entry_t own;
	dcrm_pkg::entry_t ins;
	dcrm_pkg::entry_t rem_here;
	dcrm_pkg::entry_t rem_prev;
	dcrm_pkg::entry_t nxt;
	logic             ev_own;
	logic             rem_here_lf;
	logic             rem_prev_lf;

	assign own   = '{vld: vld_q, tag: tag_q, val: val_q};
	assign ins   = '{vld: 1'b1, tag: slot, val: sample};
	assign entry = own;

	// sits below the new sample; evicted when it holds the slot being overwritten
	assign lf     = vld_q && (val_q <= sample);
	assign ev_own = vld_q && (tag_q == slot);
	assign ev_le  = ev_prev | ev_own;

	// chain with the evicted cell closed up: this place and the one before it
	assign rem_here    = ev_le ? right : own;
	assign rem_here_lf = ev_le ? right_lf : lf;
	assign rem_prev    = ev_prev ? own : left;
	assign rem_prev_lf = ev_prev ? lf : left_lf;

	// below the insert point keep, at it take the sample, above it shift up
	always_comb begin
		if (rem_here_lf) begin
			nxt = rem_here;
		end else if (rem_prev_lf) begin
			nxt = ins;
		end else begin
			nxt = rem_prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (upd) begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			tag_q <= nxt.tag;
			val_q <= nxt.val;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dcrm_chain.sv -----
// ----------------------------------------------------------------------------
// dcrm_chain: sorted window of one channel
// A row of cells kept in ascending order; one sample in, the oldest out,
// per update. The median tap picks one cell by position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcrm_chain (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          upd,
	input  wire logic [dcrm_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [dcrm_pkg::TAG_W-1:0]    slot,
	input  wire logic [dcrm_pkg::TAG_W-1:0]    sel,
	output logic      [dcrm_pkg::SAMPLE_W-1:0] median
);

	// neighbour wiring, one spare place at each end
	dcrm_pkg::entry_t              ent_w [0:dcrm_pkg::WINDOW+1];
	logic                          lf_w  [0:dcrm_pkg::WINDOW+1];
	logic                          ev_w  [0:dcrm_pkg::WINDOW];
	logic [dcrm_pkg::SAMPLE_W-1:0] val_w [0:dcrm_pkg::WINDOW-1];

	// ends of the row: nothing evicted before the first cell, empty past the last
	assign ent_w[0]                  = '0;
	assign lf_w[0]                   = 1'b1;
	assign ev_w[0]                   = 1'b0;
	assign ent_w[dcrm_pkg::WINDOW+1] = '0;
	assign lf_w[dcrm_pkg::WINDOW+1]  = 1'b0;

	for (genvar i = 0; i < dcrm_pkg::WINDOW; i++) begin : g_cell
		dcrm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (upd),
			.sample   (sample),
			.slot     (slot),
			.left     (ent_w[i]),
			.left_lf  (lf_w[i]),
			.ev_prev  (ev_w[i]),
			.right    (ent_w[i+2]),
			.right_lf (lf_w[i+2]),
			.entry    (ent_w[i+1]),
			.lf       (lf_w[i+1]),
			.ev_le    (ev_w[i+1])
		);
		assign val_w[i] = ent_w[i+1].val;
	end

	// median tap
	assign median = val_w[sel];

endmodule

`default_nettype wire

// ----- rtl/dual_channel_running_median_core.sv -----
// ----------------------------------------------------------------------------
// dual_channel_running_median_core: two channel sliding window median
// Scales voltage and current codes by their gains and returns the running
// median of each channel's last WINDOW samples.
// ----------------------------------------------------------------------------
// Pipeline: three register stages (stage 1, stage 2, output register); an accepted
// word passes through stage 1 and stage 2 and is taken from the output register.
// Throughput: one word per cycle; the sorted cell chains insert and evict one
// sample per cycle, so only output backpressure slows the block.
// Reset: clears the windows (empty), ring slot and fill count, enable to 0 and
// both gains to unity. No clearing pass; the block is ready straight away.
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_running_median_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire dcrm_pkg::in_word_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output dcrm_pkg::out_word_t                 out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [dcrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dcrm_pkg::CFG_DAT_W-1:0] cfg_data
);

	logic                          enable_q;
	logic [dcrm_pkg::GAIN_W-1:0]   vgain_q;
	logic [dcrm_pkg::GAIN_W-1:0]   igain_q;

	logic [dcrm_pkg::SAMPLE_W-1:0] vscaled;
	logic [dcrm_pkg::SAMPLE_W-1:0] iscaled;

	logic                          valid_s1;
	logic                          en_s1;
	logic [dcrm_pkg::SAMPLE_W-1:0] vsmp_s1;
	logic [dcrm_pkg::SAMPLE_W-1:0] ismp_s1;

	logic                          valid_s2;
	logic                          en_s2;

	logic [dcrm_pkg::TAG_W-1:0]    slot_q;
	logic [dcrm_pkg::CNT_W-1:0]    fill_q;
	logic [dcrm_pkg::CNT_W-1:0]    half_fill;
	logic [dcrm_pkg::TAG_W-1:0]    sel;

	logic [dcrm_pkg::SAMPLE_W-1:0] vmed;
	logic [dcrm_pkg::SAMPLE_W-1:0] imed;

	logic                          out_valid_q;
	dcrm_pkg::out_word_t           out_data_q;

	logic                          adv_s1;
	logic                          adv_s2;
	logic                          upd;

	// stage flow: each stage moves when the next one is free or moving
	assign adv_s2    = !out_valid_q || out_ready;
	assign adv_s1    = !valid_s2 || adv_s2;
	assign in_ready  = !valid_s1 || adv_s1;
	assign upd       = valid_s1 && en_s1 && adv_s1;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			vgain_q  <= dcrm_pkg::GAIN_UNITY;
			igain_q  <= dcrm_pkg::GAIN_UNITY;
		end else if (cfg_valid) begin
			case (cfg_index)
				dcrm_pkg::REG_ENABLE:       enable_q <= cfg_data[0];
				dcrm_pkg::REG_VOLTAGE_GAIN: vgain_q  <= cfg_data;
				dcrm_pkg::REG_CURRENT_GAIN: igain_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// scaling into stage 1
	dcrm_scale u_vscale (
		.code   (in_data.raw_voltage),
		.gain   (vgain_q),
		.sample (vscaled)
	);

	dcrm_scale u_iscale (
		.code   (in_data.raw_current),
		.gain   (igain_q),
		.sample (iscaled)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			en_s1   <= enable_q;
			vsmp_s1 <= vscaled;
			ismp_s1 <= iscaled;
		end
	end

	// ring slot and fill count follow every stored sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (upd) begin
			if (slot_q == dcrm_pkg::TAG_W'(dcrm_pkg::WINDOW - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + dcrm_pkg::TAG_W'(1);
			end
			if (fill_q != dcrm_pkg::CNT_W'(dcrm_pkg::WINDOW)) begin
				fill_q <= fill_q + dcrm_pkg::CNT_W'(1);
			end
		end
	end

	// sorted windows, updated as an enabled word leaves stage 1
	dcrm_chain u_vchain (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.sample (vsmp_s1),
		.slot   (slot_q),
		.sel    (sel),
		.median (vmed)
	);

	dcrm_chain u_ichain (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.sample (ismp_s1),
		.slot   (slot_q),
		.sel    (sel),
		.median (imed)
	);

	// stage 2: word sits while its chain state is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			en_s2 <= en_s1;
		end
	end

	// median position is half the fill count
	assign half_fill = fill_q >> 1;
	assign sel       = half_fill[dcrm_pkg::TAG_W-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s2) begin
			if (en_s2) begin
				out_data_q <= '{voltage_median: vmed, current_median: imed,
					valid_res: 1'b1};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/dcrm_checker.sv -----
// ----------------------------------------------------------------------------
// dcrm_checker: port checks for the running median core
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcrm_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire dcrm_pkg::out_word_t out_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// a word marked invalid carries zero medians
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.valid_res |->
			out_data.voltage_median == '0 && out_data.current_median == '0)
		else $error("invalid result with non-zero median");

	// with the output empty nothing can stall the input
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a word taken now leaves room for the next input word
	a_ready_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input stalled while result taken");

endmodule

bind dual_channel_running_median_core dcrm_checker u_dcrm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
